>>> hw/rtl/scw_pkg.sv
// shared types and constants for the sequence completion watermark
`timescale 1ns / 1ps
`default_nettype none
package scw_pkg;

    localparam int unsigned SEQ_W      = 32;
    localparam int unsigned WINDOW_DEF = 64;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned OUT_RAW_W  = 2 * SEQ_W + STATUS_W;
    localparam int unsigned OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADVANCED = 2'd0,
        ST_BUFFERED = 2'd1,
        ST_STALE    = 2'd2,
        ST_DROPPED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic cfg_load;
        logic accept;
        logic shift;
        logic load_out;
    } scw_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_next;
        logic more;
        logic out_free;
    } scw_sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/scw_dp.sv
// datapath: watermark, highest seen, pending bitmap and result register
`timescale 1ns / 1ps
`default_nettype none
module scw_dp import scw_pkg::*; #(
    parameter int unsigned WINDOW = WINDOW_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire scw_cmd_t              cmd,
    output scw_sts_t                   sts,
    input  wire logic [SEQ_W-1:0]      in_seq,
    input  wire logic [SEQ_W-1:0]      cfg_data,
    input  wire logic                  m_tready,
    output logic                       m_tvalid,
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic [SEQ_W-1:0]      watermark_reg;
    logic [SEQ_W-1:0]      highest_reg;
    logic [WINDOW-1:0]     pending_reg;
    status_t               status_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [SEQ_W-1:0] diff;
    logic [SEQ_W-1:0] offs;
    logic [IDX_W-1:0] idx;
    logic             is_stale;
    logic             is_next;
    logic             in_win;

    always_comb begin
        diff     = in_seq - watermark_reg;
        offs     = diff - SEQ_W'(2);
        idx      = offs[IDX_W-1:0];
        is_stale = (in_seq <= watermark_reg);
        is_next  = !is_stale && (diff == SEQ_W'(1));
        in_win   = !is_stale && !is_next && (offs < SEQ_W'(WINDOW));
    end

    assign sts.is_next  = is_next;
    assign sts.more     = pending_reg[0];
    assign sts.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            watermark_reg <= '0;
            highest_reg   <= '0;
            pending_reg   <= '0;
            status_reg    <= ST_ADVANCED;
        end else if (cmd.cfg_load) begin
            watermark_reg <= cfg_data;
            highest_reg   <= cfg_data;
            pending_reg   <= '0;
        end else if (cmd.accept) begin
            if (in_seq > highest_reg) begin
                highest_reg <= in_seq;
            end
            if (is_stale) begin
                status_reg <= ST_STALE;
            end else if (is_next) begin
                watermark_reg <= in_seq;
                status_reg    <= ST_ADVANCED;
            end else if (in_win) begin
                if (pending_reg[idx]) begin
                    status_reg <= ST_STALE;
                end else begin
                    pending_reg[idx] <= 1'b1;
                    status_reg       <= ST_BUFFERED;
                end
            end else begin
                status_reg <= ST_DROPPED;
            end
        end else if (cmd.shift) begin
            // the bit shifted out stands for watermark + 1
            pending_reg <= pending_reg >> 1;
            if (pending_reg[0]) begin
                watermark_reg <= watermark_reg + SEQ_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= OUT_DATA_W'({status_reg, highest_reg, watermark_reg});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

>>> hw/rtl/scw_ctrl.sv
// controller: accept, bitmap advance and result hand-off sequencing
`timescale 1ns / 1ps
`default_nettype none
module scw_ctrl import scw_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire logic     cfg_valid,
    output logic          cfg_ready,
    input  wire scw_sts_t sts,
    output scw_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        cfg_ready  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                cfg_ready = 1'b1;
                // a register write wins over a waiting item
                s_tready  = !cfg_valid;
                if (cfg_valid) begin
                    cmd.cfg_load = 1'b1;
                end else if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = sts.is_next ? S_SHIFT : S_OUT;
                end
            end
            S_SHIFT: begin
                cmd.shift = 1'b1;
                if (!sts.more) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hw/rtl/sequence_completion_watermark_top.sv
// top level of the sequence completion watermark tracker
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid / s_tready  s_tdata[31:0] completed_seq
//  m_        out  m_tvalid / m_tready  m_tdata watermark, highest_seen, status
//  cfg_      in   cfg_valid/cfg_ready  cfg_data[31:0] start_sequence
//
//  an item that does not advance the watermark goes from accept straight to the
//  result hand-off; an advancing item first walks the run of contiguous pending
//  bits, one bit per cycle, and the walk ends on one further shift. the result
//  register lets the next transaction be taken while a result waits; a stalled
//  result holds the controller in its hand-off state. reset (synchronous, active
//  low) gives watermark and highest seen 0 and clears the bitmap; a register
//  write restarts the tracker from the written value.
`timescale 1ns / 1ps
`default_nettype none
module sequence_completion_watermark_top import scw_pkg::*; #(
    parameter int unsigned WINDOW = WINDOW_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [SEQ_W-1:0]      s_tdata,   // [31:0] completed_seq
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // [31:0] watermark, [63:32] highest_seen,
                                                  // [65:64] status, rest zero
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [SEQ_W-1:0]      cfg_data   // [31:0] start_sequence
);

    scw_cmd_t cmd;
    scw_sts_t sts;

    scw_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    scw_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .in_seq   (s_tdata),
        .cfg_data (cfg_data),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire
